// File: hdl/llbt_pkg.sv
// Shared types and constants for the login lockout backoff table.
// No dependencies; used by login_lockout_backoff_table.
`default_nettype none

package llbt_pkg;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 32;
  localparam int TIME_W  = 48;
  localparam int CNT_W   = 8;
  localparam int BASE_W  = 20;
  localparam int REM_W   = 5;
  localparam int CFG_IDX_W = 1;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [BASE_W-1:0] base_t;
  typedef logic [REM_W-1:0]  removed_t;

  // Operation codes
  localparam kind_t KIND_QUERY   = 2'd0;
  localparam kind_t KIND_FAILURE = 2'd1;
  localparam kind_t KIND_SUCCESS = 2'd2;
  localparam kind_t KIND_CLEANUP = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LOCKOUT = 1'd1;

  // Reset values of the configuration registers
  localparam count_t MAX_ATTEMPTS_RST = 8'd5;
  localparam base_t  BASE_LOCKOUT_RST = 20'd30;

  // Saturation limits
  localparam count_t COUNT_MAX = 8'd255;

endpackage

`default_nettype wire

// File: hdl/login_lockout_backoff_table.sv
// Login lockout table with exponential backoff: top level and only module.
// Depends on llbt_pkg (types, op codes, register indexes).
//
//   Channel   Ports                                         Handshake
//   --------  --------------------------------------------  ------------------------
//   command   start, busy, in_kind/in_user_key/...          start && !busy
//   result    out_valid, out_allowed/out_dropped/...        out_valid, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid && cfg_ready
//
// Each command walks the whole table through one shared key/expiry compare,
// one entry per cycle from a registered memory read; after the walk a query,
// success or cleanup goes straight to the result strobe, while a failure
// that gets an entry adds a count step and a write-back with one 49-bit add
// for the expiry. A new command is taken in the strobe cycle.
// Reset (synchronous, rst_n low) empties the table at once through per-entry
// valid flops and restores the register defaults. The receiver cannot stall.
`default_nettype none

module login_lockout_backoff_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_SHIFT     = 6
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // command channel
  input  wire                            start,
  output logic                           busy,
  input  wire  [llbt_pkg::KIND_W-1:0]    in_kind,
  input  wire  [llbt_pkg::KEY_W-1:0]     in_user_key,
  input  wire  [llbt_pkg::TIME_W-1:0]    in_current_time,
  // result channel
  output logic                           out_valid,
  output logic                           out_allowed,
  output logic                           out_dropped,
  output logic [llbt_pkg::REM_W-1:0]     out_removed_count,
  // configuration channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [llbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [llbt_pkg::BASE_W-1:0]    cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SH_W  = (MAX_SHIFT > 0) ? $clog2(MAX_SHIFT + 1) : 1;
  localparam int DUR_W = llbt_pkg::BASE_W + MAX_SHIFT;
  localparam int SUM_W = llbt_pkg::TIME_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_LOCK  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Control registers
  logic [2:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     issue_r, issue_nxt;
  logic                     cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                     hit_r, hit_nxt;
  logic                     hit_le_r, hit_le_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic                     free_r, free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [llbt_pkg::CNT_W-1:0] max_att_r;
  logic [llbt_pkg::BASE_W-1:0] base_lock_r;

  // Payload registers
  llbt_pkg::kind_t    kind_r, kind_nxt;
  llbt_pkg::key_t     key_r, key_nxt;
  llbt_pkg::stamp_t   now_r, now_nxt;
  llbt_pkg::count_t   hit_fail_r, hit_fail_nxt;
  llbt_pkg::count_t   cnt_r, cnt_nxt;
  logic               lock_r, lock_nxt;
  logic [SH_W-1:0]    shift_r, shift_nxt;
  logic [IDX_W-1:0]   tgt_idx_r, tgt_idx_nxt;
  logic               allowed_r, allowed_nxt;
  logic               dropped_r, dropped_nxt;
  llbt_pkg::removed_t removed_r, removed_nxt;

  // Table memories and registered read data
  llbt_pkg::key_t   mem_key  [TABLE_ENTRIES];
  llbt_pkg::count_t mem_fail [TABLE_ENTRIES];
  llbt_pkg::stamp_t mem_exp  [TABLE_ENTRIES];
  llbt_pkg::key_t   rd_key_r;
  llbt_pkg::count_t rd_fail_r;
  llbt_pkg::stamp_t rd_exp_r;

  // Memory write controls
  logic               mem_we;
  logic               exp_we;
  llbt_pkg::stamp_t   exp_wdata;

  // Shared compare and datapath terms
  logic               entry_valid;
  logic               exp_le;
  logic               key_eq;
  llbt_pkg::count_t   base_cnt;
  llbt_pkg::count_t   cnt_inc;
  llbt_pkg::count_t   excess;
  logic [DUR_W-1:0]   dur;
  logic [SUM_W-1:0]   sum;
  llbt_pkg::stamp_t   sum_sat;

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_allowed       = allowed_r;
  assign out_dropped       = dropped_r;
  assign out_removed_count = removed_r;

  // Shared compare unit over the entry just read
  assign entry_valid = valid_r[cmp_idx_r];
  assign exp_le      = (rd_exp_r <= now_r);
  assign key_eq      = (rd_key_r == key_r);

  // Failure count and backoff arithmetic
  assign base_cnt = hit_r ? hit_fail_r : '0;
  assign cnt_inc  = (base_cnt == llbt_pkg::COUNT_MAX) ? base_cnt : base_cnt + 8'd1;
  assign excess   = cnt_inc - max_att_r;
  assign dur      = DUR_W'(base_lock_r) << shift_r;
  assign sum      = {1'b0, now_r} + SUM_W'(dur);
  assign sum_sat  = sum[SUM_W-1] ? '1 : sum[llbt_pkg::TIME_W-1:0];

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    cmp_en_nxt    = 1'b0;
    cmp_idx_nxt   = idx_r;
    hit_nxt       = hit_r;
    hit_le_nxt    = hit_le_r;
    hit_idx_nxt   = hit_idx_r;
    hit_fail_nxt  = hit_fail_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    cnt_nxt       = cnt_r;
    lock_nxt      = lock_r;
    shift_nxt     = shift_r;
    tgt_idx_nxt   = tgt_idx_r;
    allowed_nxt   = allowed_r;
    dropped_nxt   = dropped_r;
    removed_nxt   = removed_r;
    mem_we        = 1'b0;
    exp_we        = 1'b0;
    exp_wdata     = sum_sat;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt    = in_kind;
          key_nxt     = in_user_key;
          now_nxt     = in_current_time;
          idx_nxt     = '0;
          issue_nxt   = 1'b1;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          allowed_nxt = 1'b0;
          dropped_nxt = 1'b0;
          removed_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (issue_r) begin
          cmp_en_nxt = 1'b1;
          if (idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // evaluate the entry read last cycle
        if (cmp_en_r) begin
          if (kind_r == llbt_pkg::KIND_CLEANUP) begin
            if (entry_valid && (rd_exp_r != '0) && exp_le) begin
              valid_nxt[cmp_idx_r] = 1'b0;
              if (removed_r != '1) begin
                removed_nxt = removed_r + 1'b1;
              end
            end
          end else begin
            if (entry_valid && key_eq && !hit_r) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = cmp_idx_r;
              hit_fail_nxt = rd_fail_r;
              hit_le_nxt   = exp_le;
            end
            if (!entry_valid && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
          end
        end
        // walk finished: settle the operation
        if (!issue_r && !cmp_en_r) begin
          state_nxt = S_DONE;
          case (kind_r)
            llbt_pkg::KIND_QUERY: begin
              allowed_nxt = !hit_r || hit_le_r;
            end
            llbt_pkg::KIND_FAILURE: begin
              if (!hit_r && !free_r) begin
                dropped_nxt = 1'b1;
              end else begin
                tgt_idx_nxt = hit_r ? hit_idx_r : free_idx_r;
                state_nxt   = S_LOCK;
              end
            end
            llbt_pkg::KIND_SUCCESS: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                removed_nxt          = llbt_pkg::removed_t'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // count the failure and pick the backoff shift
      S_LOCK: begin
        cnt_nxt   = cnt_inc;
        lock_nxt  = (cnt_inc >= max_att_r);
        shift_nxt = (excess < llbt_pkg::count_t'(MAX_SHIFT)) ? SH_W'(excess)
                                                              : SH_W'(MAX_SHIFT);
        state_nxt = S_WRITE;
      end

      // write the entry back; a new entry without lockout gets expiry 0
      S_WRITE: begin
        mem_we                 = 1'b1;
        valid_nxt[tgt_idx_r]   = 1'b1;
        if (lock_r) begin
          exp_we    = 1'b1;
          exp_wdata = sum_sat;
        end else if (!hit_r) begin
          exp_we    = 1'b1;
          exp_wdata = '0;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      cmp_en_r    <= 1'b0;
      cmp_idx_r   <= '0;
      hit_r       <= 1'b0;
      hit_le_r    <= 1'b0;
      hit_idx_r   <= '0;
      free_r      <= 1'b0;
      free_idx_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      allowed_r   <= 1'b0;
      dropped_r   <= 1'b0;
      removed_r   <= '0;
      max_att_r   <= llbt_pkg::MAX_ATTEMPTS_RST;
      base_lock_r <= llbt_pkg::BASE_LOCKOUT_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      issue_r     <= issue_nxt;
      cmp_en_r    <= cmp_en_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      hit_r       <= hit_nxt;
      hit_le_r    <= hit_le_nxt;
      hit_idx_r   <= hit_idx_nxt;
      free_r      <= free_nxt;
      free_idx_r  <= free_idx_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      allowed_r   <= allowed_nxt;
      dropped_r   <= dropped_nxt;
      removed_r   <= removed_nxt;
      // configuration transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          llbt_pkg::REG_MAX_ATTEMPTS: max_att_r   <= cfg_data[llbt_pkg::CNT_W-1:0];
          llbt_pkg::REG_BASE_LOCKOUT: base_lock_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    hit_fail_r <= hit_fail_nxt;
    cnt_r      <= cnt_nxt;
    lock_r     <= lock_nxt;
    shift_r    <= shift_nxt;
    tgt_idx_r  <= tgt_idx_nxt;
  end

  // Table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[tgt_idx_r]  <= key_r;
      mem_fail[tgt_idx_r] <= cnt_r;
    end
    if (exp_we) begin
      mem_exp[tgt_idx_r] <= exp_wdata;
    end
    rd_key_r  <= mem_key[idx_r];
    rd_fail_r <= mem_fail[idx_r];
    rd_exp_r  <= mem_exp[idx_r];
  end

  // Assertions
  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished command");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while sequencer busy");

  a_drop_only_failure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dropped) |-> (kind_r == llbt_pkg::KIND_FAILURE))
    else $error("drop flagged for a command other than failure");

  a_allow_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_allowed) |-> (kind_r == llbt_pkg::KIND_QUERY))
    else $error("allowed set for a command other than query");

  a_removed_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_removed_count != '0)) |->
      ((kind_r == llbt_pkg::KIND_CLEANUP) ||
       ((kind_r == llbt_pkg::KIND_SUCCESS) && (out_removed_count == 5'd1))))
    else $error("removal count inconsistent with command");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for login_lockout_backoff_table: directed and random
// command transactions checked against an in-bench model of the lockout table.
// Depends on llbt_pkg (types, op codes, register indexes) and the DUT.
`timescale 1ns / 100ps

module testbench;

  localparam int               ENTRIES     = 16;
  localparam int               SHIFT_CAP   = 6;
  localparam int               LATENCY     = ENTRIES + 8;
  localparam int               QUIET_LIMIT = 2000;
  localparam int               POOL_SIZE   = 24;
  localparam llbt_pkg::stamp_t STAMP_MAX   = '1;

  typedef struct packed {
    logic               allowed;
    logic               dropped;
    llbt_pkg::removed_t removed;
  } verdict_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  llbt_pkg::kind_t                in_kind = llbt_pkg::KIND_QUERY;
  llbt_pkg::key_t                 in_user_key = '0;
  llbt_pkg::stamp_t               in_current_time = '0;
  logic                           out_valid;
  logic                           out_allowed;
  logic                           out_dropped;
  llbt_pkg::removed_t             out_removed_count;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [llbt_pkg::CFG_IDX_W-1:0] cfg_index = llbt_pkg::REG_MAX_ATTEMPTS;
  llbt_pkg::base_t                cfg_data = '0;

  // Model of the lockout table and its registers
  logic             tbl_valid [ENTRIES];
  llbt_pkg::key_t   tbl_key   [ENTRIES];
  llbt_pkg::count_t tbl_count [ENTRIES];
  llbt_pkg::stamp_t tbl_expiry[ENTRIES];
  llbt_pkg::count_t lim_attempts = llbt_pkg::MAX_ATTEMPTS_RST;
  llbt_pkg::base_t  base_len     = llbt_pkg::BASE_LOCKOUT_RST;

  verdict_t         verdict_q[$];
  int               n_err       = 0;
  int               quiet_cycles = 0;
  bit               no_idle     = 1'b0;
  llbt_pkg::key_t   user_pool[POOL_SIZE];
  llbt_pkg::stamp_t clock_now   = '0;

  login_lockout_backoff_table #(
    .TABLE_ENTRIES (ENTRIES),
    .MAX_SHIFT     (SHIFT_CAP)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_user_key       (in_user_key),
    .in_current_time   (in_current_time),
    .out_valid         (out_valid),
    .out_allowed       (out_allowed),
    .out_dropped       (out_dropped),
    .out_removed_count (out_removed_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one command to the model table; returns the expected result
  function automatic verdict_t lockout_predict(llbt_pkg::kind_t op, llbt_pkg::key_t key,
                                               llbt_pkg::stamp_t now);
    verdict_t    v;
    int          hit;
    int unsigned over;
    int unsigned sh;
    logic [63:0] span;
    logic [63:0] total;
    v   = '0;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
    case (op)
      llbt_pkg::KIND_QUERY: begin
        if (hit < 0) v.allowed = 1'b1;
        else v.allowed = (tbl_expiry[hit] <= now);
      end
      llbt_pkg::KIND_FAILURE: begin
        // absent user takes the lowest free entry
        if (hit < 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && !tbl_valid[i]) hit = i;
          if (hit >= 0) begin
            tbl_valid[hit]  = 1'b1;
            tbl_key[hit]    = key;
            tbl_count[hit]  = '0;
            tbl_expiry[hit] = '0;
          end
        end
        if (hit < 0) begin
          v.dropped = 1'b1;
        end else begin
          if (tbl_count[hit] != llbt_pkg::COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 1'b1;
          // lockout doubles per failure past the threshold, capped shift
          if (tbl_count[hit] >= lim_attempts) begin
            over  = tbl_count[hit] - lim_attempts;
            sh    = (over < SHIFT_CAP) ? over : SHIFT_CAP;
            span  = 64'(base_len) << sh;
            total = 64'(now) + span;
            tbl_expiry[hit] = (total > 64'(STAMP_MAX)) ? STAMP_MAX
                                                       : total[llbt_pkg::TIME_W-1:0];
          end
        end
      end
      llbt_pkg::KIND_SUCCESS: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          v.removed      = llbt_pkg::removed_t'(1);
        end
      end
      default: begin
        // sweep: expired entries go, never-locked ones stay
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_expiry[i] != '0 && tbl_expiry[i] <= now) begin
            tbl_valid[i] = 1'b0;
            if (v.removed != '1) v.removed = v.removed + 1'b1;
          end
        end
      end
    endcase
    return v;
  endfunction

  function automatic llbt_pkg::stamp_t rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[llbt_pkg::TIME_W-1:0];
  endfunction

  // Send one command transaction; start is left high on return
  task automatic send_cmd(input llbt_pkg::kind_t op, input llbt_pkg::key_t key,
                          input llbt_pkg::stamp_t now);
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= op;
    in_user_key     <= key;
    in_current_time <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdict_q.push_back(lockout_predict(op, key, now));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [llbt_pkg::CFG_IDX_W-1:0] idx,
                           input llbt_pkg::base_t data);
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == llbt_pkg::REG_MAX_ATTEMPTS) lim_attempts = data[llbt_pkg::CNT_W-1:0];
    else base_len = data;
  endtask

  // Program both registers while the table is idle
  task automatic program_regs(input llbt_pkg::count_t attempts,
                              input llbt_pkg::base_t lockout);
    llbt_pkg::base_t wide;
    wide = llbt_pkg::base_t'($urandom);
    wide[llbt_pkg::CNT_W-1:0] = attempts;
    wait_idle();
    write_reg(llbt_pkg::REG_MAX_ATTEMPTS, wide);
    write_reg(llbt_pkg::REG_BASE_LOCKOUT, lockout);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Remove every entry the model holds, one success each
  task automatic clear_table();
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i]) send_cmd(llbt_pkg::KIND_SUCCESS, tbl_key[i], rand_stamp());
  endtask

  // Reset register values: threshold, first lockout, doubling, sweep
  task automatic test_reset_defaults();
    send_cmd(llbt_pkg::KIND_QUERY, 32'hFFFF_FFFF, STAMP_MAX);
    send_cmd(llbt_pkg::KIND_SUCCESS, 32'h0, 48'd0);
    send_cmd(llbt_pkg::KIND_CLEANUP, 32'h1234_5678, 48'd0);
    repeat (5) send_cmd(llbt_pkg::KIND_FAILURE, 32'h0, 48'd100);
    send_cmd(llbt_pkg::KIND_QUERY, 32'h0, 48'd129);
    send_cmd(llbt_pkg::KIND_QUERY, 32'h0, 48'd130);
    send_cmd(llbt_pkg::KIND_FAILURE, 32'h0, 48'd200);
    send_cmd(llbt_pkg::KIND_CLEANUP, 32'h0, 48'd260);
  endtask

  // Zero threshold, shift cap, expiry saturation, zero lockout
  task automatic test_config_extremes();
    program_regs(8'd0, 20'd1);
    repeat (7) send_cmd(llbt_pkg::KIND_FAILURE, 32'hFFFF_FFFF, 48'd1000);
    send_cmd(llbt_pkg::KIND_QUERY, 32'hFFFF_FFFF, 48'd1063);
    send_cmd(llbt_pkg::KIND_QUERY, 32'hFFFF_FFFF, 48'd1064);
    program_regs(8'd0, 20'hFFFFF);
    send_cmd(llbt_pkg::KIND_FAILURE, 32'h8000_0001, STAMP_MAX - 5);
    send_cmd(llbt_pkg::KIND_QUERY, 32'h8000_0001, STAMP_MAX - 1);
    send_cmd(llbt_pkg::KIND_QUERY, 32'h8000_0001, STAMP_MAX);
    send_cmd(llbt_pkg::KIND_CLEANUP, 32'h0, STAMP_MAX);
    program_regs(8'd0, 20'd0);
    send_cmd(llbt_pkg::KIND_FAILURE, 32'h0000_7FFF, 48'd0);
    send_cmd(llbt_pkg::KIND_QUERY, 32'h0000_7FFF, 48'd0);
    send_cmd(llbt_pkg::KIND_CLEANUP, 32'h0, 48'd0);
  endtask

  // Fill every entry, then failures for new users must be dropped
  task automatic test_table_full();
    llbt_pkg::key_t k;
    program_regs(llbt_pkg::MAX_ATTEMPTS_RST, llbt_pkg::BASE_LOCKOUT_RST);
    clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      k = ($urandom & 32'hFFFF_FFE0) | llbt_pkg::key_t'(i);
      send_cmd(llbt_pkg::KIND_FAILURE, k, rand_stamp());
    end
    repeat (3) send_cmd(llbt_pkg::KIND_FAILURE, ($urandom & 32'hFFFF_FFE0) | 32'h10,
                        rand_stamp());
    send_cmd(llbt_pkg::KIND_FAILURE, tbl_key[3], clock_now);
    send_cmd(llbt_pkg::KIND_QUERY, tbl_key[3], clock_now);
    send_cmd(llbt_pkg::KIND_SUCCESS, tbl_key[5], clock_now);
    send_cmd(llbt_pkg::KIND_FAILURE, 32'hDEAD_0011, clock_now);
    send_cmd(llbt_pkg::KIND_FAILURE, 32'hDEAD_0012, clock_now);
    send_cmd(llbt_pkg::KIND_CLEANUP, 32'h0, STAMP_MAX);
  endtask

  // Failure count held at its maximum; no idling through this stretch
  task automatic test_count_saturation();
    llbt_pkg::key_t   k;
    llbt_pkg::stamp_t t;
    program_regs(8'd250, 20'd3);
    clear_table();
    no_idle = 1'b1;
    k = $urandom;
    t = 48'd5000;
    for (int i = 0; i < 258; i++) begin
      t = t + $urandom_range(1, 9);
      send_cmd(llbt_pkg::KIND_FAILURE, k, t);
      if (i % 64 == 63) send_cmd(llbt_pkg::KIND_QUERY, k, t + $urandom_range(0, 120));
    end
    send_cmd(llbt_pkg::KIND_QUERY, k, t + 95);
    send_cmd(llbt_pkg::KIND_QUERY, k, t + 96);
    send_cmd(llbt_pkg::KIND_SUCCESS, k, t);
    no_idle = 1'b0;
  endtask

  // Random commands over a key pool, through several register settings
  task automatic test_random_mix();
    int               r;
    llbt_pkg::kind_t  op;
    llbt_pkg::key_t   key;
    llbt_pkg::stamp_t now;
    user_pool[0] = '0;
    user_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) user_pool[i] = $urandom;
    clock_now = rand_stamp() >> 8;
    for (int round = 0; round < 6; round++) begin
      case (round)
        0:       program_regs(8'd255, 20'hFFFFF);
        1:       program_regs(8'd0, 20'd0);
        default: program_regs(llbt_pkg::count_t'($urandom_range(1, 6)),
                              llbt_pkg::base_t'($urandom_range(1, 24)));
      endcase
      for (int n = 0; n < 20; n++) begin
        r = $urandom_range(0, 99);
        if (r < 25) op = llbt_pkg::KIND_QUERY;
        else if (r < 65) op = llbt_pkg::KIND_FAILURE;
        else if (r < 80) op = llbt_pkg::KIND_SUCCESS;
        else op = llbt_pkg::KIND_CLEANUP;
        key = ($urandom_range(0, 9) == 0) ? llbt_pkg::key_t'($urandom)
                                          : user_pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 99);
        if (r < 5) begin
          clock_now = rand_stamp();
          now = clock_now;
        end else if (r < 10) begin
          now = rand_stamp();
        end else begin
          clock_now = clock_now + $urandom_range(0, 40);
          now = clock_now;
        end
        // occasional hold-off until the table has answered everything
        if ($urandom_range(0, 99) < 3) wait_idle();
        send_cmd(op, key, now);
      end
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result allowed %0b dropped %0b removed %0d",
                 $time, out_allowed, out_dropped, out_removed_count);
      end else begin
        want = verdict_q.pop_front();
        if (out_allowed !== want.allowed || out_dropped !== want.dropped ||
            out_removed_count !== want.removed) begin
          n_err++;
          $display("%0t: mismatch exp allowed %0b dropped %0b removed %0d, got %0b %0b %0d",
                   $time, want.allowed, want.dropped, want.removed,
                   out_allowed, out_dropped, out_removed_count);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_key[i]    = '0;
      tbl_count[i]  = '0;
      tbl_expiry[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_table_full();
    test_count_saturation();
    test_random_mix();
    wait_idle();
    repeat (LATENCY) @(posedge clk);
    if (n_err == 0 && verdict_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
